/* design/hdtp_pkg.sv */
// Package for the heading turn proportional controller.
// Holds the configuration and stage structs, register indexes and shared constants.
// No dependencies.
package hdtp_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_POWER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_POWER = 3'd4;

  localparam logic [6:0]  MAX_POWER_RST = 7'd40;
  localparam logic [15:0] TIMEOUT_RST   = 16'd2500;
  localparam logic [11:0] GAIN_RST      = 12'd1100;
  localparam logic [14:0] TOLERANCE_RST = 15'd250;
  localparam logic [6:0]  MIN_POWER_RST = 7'd12;

  localparam int FULL_TURN_CD = 36000;
  localparam logic signed [17:0] HALF_TURN_S = 18'sd18000;
  localparam logic signed [17:0] FULL_TURN_S = 18'sd36000;

  // Reciprocal of 3125 scaled by 2^35, rounded up; exact for dividends below 2^23.
  localparam logic [23:0] RECIP_3125 = 24'd10995117;
  localparam int RECIP_SHIFT = 35;

  typedef struct packed {
    logic [6:0]  max_power_pct;
    logic [15:0] timeout_ms;
    logic [11:0] gain_milli;
    logic [14:0] tolerance_centideg;
    logic [6:0]  min_power_pct;
  } cfg_t;

  typedef struct packed {
    logic        finished;
    logic        timed_out;
    logic        drive;
    logic        err_neg;
    logic [15:0] err_mag;
  } turn_t;

  typedef struct packed {
    logic        finished;
    logic        timed_out;
    logic        drive;
    logic        err_neg;
    logic [27:0] product;
  } scaled_t;

  // Reduces any 18-bit signed target into 0..35999 by choosing the one
  // candidate offset by a multiple of a full turn that lands in range.
  function automatic logic [15:0] wrap_target(input logic signed [17:0] t);
    logic signed [19:0] cand;
    logic [15:0]        res;
    res = '0;
    for (int k = -3; k <= 4; k++) begin
      cand = {{2{t[17]}}, t} + 20'(k * FULL_TURN_CD);
      if (!cand[19] && (cand < 20'sd36000)) begin
        res = cand[15:0];
      end
    end
    return res;
  endfunction

endpackage

/* design/heading_turn_p_controller.sv */
// Top level of the proportional turn-to-heading controller.
// Depends on hdtp_pkg, hdtp_cfg_regs, hdtp_track and hdtp_drive.
//
//   Channel  Handshake            Payload
//   in       in_valid / in_stall  begin_turn, target, heading, time
//   out      out_valid/out_stall  left_power, right_power, finished, timed_out
//   cfg      cfg_we               cfg_index, cfg_wdata
//
// One transaction is accepted per cycle while in_stall is low.
// The stages are the input register, the decision stage that updates the turn state,
// the gain multiply, and the reciprocal divide with clamping into the result register.
// Reset is synchronous and clears the turn state and restores register defaults.
// A stalled output holds its result while bubbles in earlier stages still fill.
module heading_turn_p_controller (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_begin_turn,
  input  logic signed [17:0]               in_target_centideg,
  input  logic [15:0]                      in_heading_centideg,
  input  logic [31:0]                      in_time_ms,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [7:0]                out_left_power,
  output logic signed [7:0]                out_right_power,
  output logic                             out_finished,
  output logic                             out_timed_out,
  input  logic                             cfg_we,
  input  logic [hdtp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hdtp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import hdtp_pkg::*;

  cfg_t  cfg;
  logic  a_valid;
  logic  a_ready;
  turn_t a_res;

  hdtp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  hdtp_track u_track (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_begin_turn       (in_begin_turn),
    .in_target_centideg  (in_target_centideg),
    .in_heading_centideg (in_heading_centideg),
    .in_time_ms          (in_time_ms),
    .cfg                 (cfg),
    .a_valid             (a_valid),
    .a_ready             (a_ready),
    .a_res               (a_res)
  );

  hdtp_drive u_drive (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .a_valid         (a_valid),
    .a_ready         (a_ready),
    .a_res           (a_res),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_left_power  (out_left_power),
    .out_right_power (out_right_power),
    .out_finished    (out_finished),
    .out_timed_out   (out_timed_out)
  );

endmodule

/* design/hdtp_cfg_regs.sv */
// Configuration register file of the heading turn controller.
// Depends on hdtp_pkg for the register indexes, reset values and cfg_t.
module hdtp_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [hdtp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hdtp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output hdtp_pkg::cfg_t                   cfg
);
  import hdtp_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_MAX_POWER: cfg_nxt.max_power_pct      = cfg_wdata[6:0];
        REG_TIMEOUT:   cfg_nxt.timeout_ms         = cfg_wdata;
        REG_GAIN:      cfg_nxt.gain_milli         = cfg_wdata[11:0];
        REG_TOLERANCE: cfg_nxt.tolerance_centideg = cfg_wdata[14:0];
        REG_MIN_POWER: cfg_nxt.min_power_pct      = cfg_wdata[6:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_power_pct      <= MAX_POWER_RST;
      cfg_r.timeout_ms         <= TIMEOUT_RST;
      cfg_r.gain_milli         <= GAIN_RST;
      cfg_r.tolerance_centideg <= TOLERANCE_RST;
      cfg_r.min_power_pct      <= MIN_POWER_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* design/hdtp_track.sv */
// Input register, turn state and decision stage of the heading turn controller.
// Depends on hdtp_pkg for cfg_t, turn_t and the target wrap function.
module hdtp_track (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_begin_turn,
  input  logic signed [17:0]    in_target_centideg,
  input  logic [15:0]           in_heading_centideg,
  input  logic [31:0]           in_time_ms,
  input  hdtp_pkg::cfg_t        cfg,
  output logic                  a_valid,
  input  logic                  a_ready,
  output hdtp_pkg::turn_t       a_res
);
  import hdtp_pkg::*;

  logic        v0_r;
  logic        begin_r;
  logic [15:0] tgt_r;
  logic [15:0] head_r;
  logic [31:0] time_r;

  logic        turn_active_r;
  logic [31:0] start_time_r;
  logic [15:0] target_wrapped_r;

  logic        a_valid_r;
  turn_t       a_res_r;
  turn_t       a_res_nxt;

  logic        a_adv;
  logic        a_fire;
  logic        rdy0;
  logic        active;
  logic [15:0] tgt_use;
  logic [31:0] st_use;
  logic [31:0] elapsed;
  logic        tmo;
  logic        settle;
  logic signed [17:0] err0;
  logic signed [17:0] err1;
  logic signed [17:0] err2;
  logic signed [17:0] err_abs;

  assign a_adv    = !a_valid_r || a_ready;
  assign a_fire   = v0_r && a_adv;
  assign rdy0     = !v0_r || a_adv;
  assign in_stall = !rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (rdy0) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) begin
      begin_r <= in_begin_turn;
      tgt_r   <= wrap_target(in_target_centideg);
      head_r  <= in_heading_centideg;
      time_r  <= in_time_ms;
    end
  end

  always_comb begin
    tgt_use = begin_r ? tgt_r : target_wrapped_r;
    st_use  = begin_r ? time_r : start_time_r;
    active  = begin_r || turn_active_r;
    elapsed = time_r - st_use;
    tmo     = elapsed >= {16'd0, cfg.timeout_ms};
    err0    = signed'({2'b00, tgt_use}) - signed'({2'b00, head_r});
    err1    = (err0 > HALF_TURN_S) ? err0 - FULL_TURN_S : err0;
    err2    = (err1 < -HALF_TURN_S) ? err1 + FULL_TURN_S : err1;
    err_abs = err2[17] ? -err2 : err2;
    settle  = err_abs[15:0] < {1'b0, cfg.tolerance_centideg};
    a_res_nxt.finished  = active && (tmo || settle);
    a_res_nxt.timed_out = active && tmo;
    a_res_nxt.drive     = active && !tmo && !settle;
    a_res_nxt.err_neg   = err2[17];
    a_res_nxt.err_mag   = err_abs[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_active_r    <= 1'b0;
      start_time_r     <= '0;
      target_wrapped_r <= '0;
    end else if (a_fire) begin
      turn_active_r <= a_res_nxt.drive;
      if (begin_r) begin
        start_time_r     <= time_r;
        target_wrapped_r <= tgt_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_adv) begin
      a_valid_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire) begin
      a_res_r <= a_res_nxt;
    end
  end

  assign a_valid = a_valid_r;
  assign a_res   = a_res_r;

  a_end_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (a_fire && a_res_nxt.finished) |=> !turn_active_r)
    else $error("turn still active after an ending transaction");

  a_timeout_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && a_res_r.timed_out) |-> a_res_r.finished)
    else $error("timeout flagged without finish");

  a_drive_not_end: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && a_res_r.drive) |-> !a_res_r.finished)
    else $error("turning transaction also marked finished");

endmodule

/* design/hdtp_drive.sv */
// Gain scaling, power clamp and result register of the heading turn controller.
// Depends on hdtp_pkg for cfg_t, turn_t, scaled_t and the reciprocal constant.
module hdtp_drive (
  input  logic               clk,
  input  logic               rst_n,
  input  hdtp_pkg::cfg_t     cfg,
  input  logic               a_valid,
  output logic               a_ready,
  input  hdtp_pkg::turn_t    a_res,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [7:0]  out_left_power,
  output logic signed [7:0]  out_right_power,
  output logic               out_finished,
  output logic               out_timed_out
);
  import hdtp_pkg::*;

  logic        b_valid_r;
  scaled_t     b_r;
  scaled_t     b_nxt;
  logic        b_adv;
  logic        rdy_out;

  logic        out_valid_r;
  logic signed [7:0] out_left_r;
  logic signed [7:0] out_left_nxt;
  logic        out_finished_r;
  logic        out_timed_out_r;

  logic [22:0] quot_in;
  logic [46:0] recip_prod;
  logic [11:0] quot;
  logic [6:0]  clamped;
  logic [6:0]  mag;
  logic        pos;

  assign rdy_out = !out_valid_r || !out_stall;
  assign b_adv   = !b_valid_r || rdy_out;
  assign a_ready = b_adv;

  always_comb begin
    b_nxt.finished  = a_res.finished;
    b_nxt.timed_out = a_res.timed_out;
    b_nxt.drive     = a_res.drive;
    b_nxt.err_neg   = a_res.err_neg;
    b_nxt.product   = {12'd0, a_res.err_mag} * {16'd0, cfg.gain_milli};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_adv) begin
      b_valid_r <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && a_valid) begin
      b_r <= b_nxt;
    end
  end

  always_comb begin
    quot_in    = b_r.product[27:5];
    recip_prod = {24'd0, quot_in} * {23'd0, RECIP_3125};
    quot       = recip_prod[46:RECIP_SHIFT];
    clamped    = (quot > {5'd0, cfg.max_power_pct}) ? cfg.max_power_pct : quot[6:0];
    pos        = !b_r.err_neg && (clamped != 7'd0);
    mag        = (clamped < cfg.min_power_pct) ? cfg.min_power_pct : clamped;
    if (b_r.drive) begin
      out_left_nxt = pos ? signed'({1'b0, mag}) : -signed'({1'b0, mag});
    end else begin
      out_left_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy_out) begin
      out_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out && b_valid_r) begin
      out_left_r      <= out_left_nxt;
      out_finished_r  <= b_r.finished;
      out_timed_out_r <= b_r.timed_out;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_left_power  = out_left_r;
  assign out_right_power = -out_left_r;
  assign out_finished    = out_finished_r;
  assign out_timed_out   = out_timed_out_r;

  a_finish_brakes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_finished_r) |-> (out_left_r == 8'sd0))
    else $error("motors not braked on a finishing transaction");

  a_scaled_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && rdy_out) |=> out_valid_r)
    else $error("scaled transaction lost before the result register");

  a_power_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_finished_r) |->
      ((out_left_r != -8'sd128) && !out_timed_out_r))
    else $error("turning result out of range or flagged as timeout");

endmodule
